// ===== src/prp_pkg.sv =====
// Package for the priority rotation print position block.
// Holds sizing constants, the sequencer state type and the level tracker control struct.
// No dependencies.
package prp_pkg;

    localparam int MAX_JOBS        = 128;
    localparam int PRIORITY_LEVELS = 9;

    localparam int PRIO_W   = 4;                            // priority_req port width
    localparam int TGT_W    = 7;                            // target_index port width
    localparam int POS_W    = 8;                            // print_position port width
    localparam int IDX_W    = $clog2(MAX_JOBS);
    localparam int CNT_W    = $clog2(MAX_JOBS + 1);
    localparam int LVL_W    = $clog2(PRIORITY_LEVELS + 1);
    localparam int NUM_LVLS = PRIORITY_LEVELS + 1;
    localparam int CMP_W    = (CNT_W > TGT_W) ? CNT_W + 1 : TGT_W + 1;

    typedef enum logic [1:0] {
        S_LOAD,
        S_SCAN,
        S_EMIT
    } prp_state_t;

    typedef struct packed {
        logic             inc;
        logic [LVL_W-1:0] inc_lvl;
        logic             dec;
        logic [LVL_W-1:0] dec_lvl;
        logic             clr;
    } lvl_ctrl_t;

endpackage

// ===== src/priority_rotation_print_position.sv =====
// Priority rotation print position: loads a batch of job priorities, then replays
// rotating-queue service as a circular scan to find the target job's position.
// Depends on prp_pkg and prp_level_track.
// A final beat whose target is out of range goes straight to the result; otherwise
// the scan over the job RAM checks one job per cycle (one RAM read port).
// Reset (async, active low) clears control state and level counts, not the job RAM or
// data registers; each job's served mark is cleared in the RAM as the job is loaded.
module priority_rotation_print_position
    import prp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    output logic              job_ready,
    input  logic [PRIO_W-1:0] priority_req,
    input  logic [TGT_W-1:0]  target_index,
    input  logic              last,
    output logic              result_valid,
    input  logic              result_ready,
    output logic [POS_W-1:0]  print_position,
    output logic              found
);

    prp_state_t state_reg, state_next;

    // entry: {served mark, priority level}
    logic [LVL_W:0]      job_mem [MAX_JOBS];
    logic [LVL_W:0]      rd_data_reg;

    logic [CNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    ptr_reg, ptr_next;
    logic                cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]    cmp_ptr_reg, cmp_ptr_next;
    logic [CNT_W-1:0]    served_cnt_reg, served_cnt_next;
    logic [TGT_W-1:0]    target_reg, target_next;
    logic                found_reg, found_next;
    logic [POS_W-1:0]    pos_reg, pos_next;

    logic                out_valid_reg, out_valid_next;
    logic [POS_W-1:0]    out_pos_reg, out_pos_next;
    logic                out_found_reg, out_found_next;

    logic                job_beat;
    logic                mem_wr;
    logic [LVL_W-1:0]    prio_sat;
    logic [LVL_W-1:0]    top_level;
    logic                hit;
    logic [CNT_W:0]      ptr_inc;
    lvl_ctrl_t           lvl_ctrl;

    assign job_ready = (state_reg == S_LOAD);
    assign job_beat  = job_valid && job_ready;
    assign mem_wr    = job_beat && (count_reg < CNT_W'(MAX_JOBS));

    always_comb
    begin
        if (priority_req > PRIO_W'(PRIORITY_LEVELS))
        begin
            prio_sat = LVL_W'(PRIORITY_LEVELS);
        end
        else
        begin
            prio_sat = LVL_W'(priority_req);
        end
    end

    // job RAM: one write port shared by loading and served marking,
    // one registered read port for the scan
    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            job_mem[count_reg[IDX_W-1:0]] <= {1'b0, prio_sat};
        end
        else if (hit)
        begin
            job_mem[cmp_ptr_reg] <= {1'b1, rd_data_reg[LVL_W-1:0]};
        end
        rd_data_reg <= job_mem[ptr_reg];
    end

    prp_level_track u_level_track (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (lvl_ctrl),
        .top_level (top_level)
    );

    // a ring of one job is always served on its first check, so a read never
    // races the served-mark write to the same entry
    assign hit = (state_reg == S_SCAN) && cmp_valid_reg && !rd_data_reg[LVL_W]
                 && (rd_data_reg[LVL_W-1:0] == top_level);
    assign ptr_inc = (CNT_W + 1)'(ptr_reg) + (CNT_W + 1)'(1);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        cmp_valid_next  = cmp_valid_reg;
        cmp_ptr_next    = cmp_ptr_reg;
        served_cnt_next = served_cnt_reg;
        target_next     = target_reg;
        found_next      = found_reg;
        pos_next        = pos_reg;
        out_valid_next  = out_valid_reg && !result_ready;
        out_pos_next    = out_pos_reg;
        out_found_next  = out_found_reg;

        lvl_ctrl         = '0;
        lvl_ctrl.inc     = mem_wr;
        lvl_ctrl.inc_lvl = prio_sat;

        unique case (state_reg)
            S_LOAD:
            begin
                if (mem_wr)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                if (job_beat && last)
                begin
                    target_next    = target_index;
                    found_next     = (CMP_W'(target_index) < CMP_W'(count_next));
                    pos_next       = '0;
                    ptr_next       = '0;
                    cmp_valid_next = 1'b0;
                    if (CMP_W'(target_index) < CMP_W'(count_next))
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
            end

            S_SCAN:
            begin
                // issue side: walk the ring of loaded jobs
                cmp_valid_next = 1'b1;
                cmp_ptr_next   = ptr_reg;
                if (ptr_inc < (CNT_W + 1)'(count_reg))
                begin
                    ptr_next = ptr_inc[IDX_W-1:0];
                end
                else
                begin
                    ptr_next = '0;
                end
                // check side: serve the front job when it holds the top level
                if (hit)
                begin
                    served_cnt_next  = served_cnt_reg + CNT_W'(1);
                    lvl_ctrl.dec     = 1'b1;
                    lvl_ctrl.dec_lvl = rd_data_reg[LVL_W-1:0];
                    if (CMP_W'(cmp_ptr_reg) == CMP_W'(target_reg))
                    begin
                        pos_next   = POS_W'(served_cnt_reg + CNT_W'(1));
                        state_next = S_EMIT;
                    end
                end
            end

            S_EMIT:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_pos_next    = pos_reg;
                    out_found_next  = found_reg;
                    count_next      = '0;
                    ptr_next        = '0;
                    cmp_valid_next  = 1'b0;
                    served_cnt_next = '0;
                    lvl_ctrl.clr    = 1'b1;
                    state_next      = S_LOAD;
                end
            end

            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            count_reg      <= '0;
            ptr_reg        <= '0;
            cmp_valid_reg  <= 1'b0;
            served_cnt_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            ptr_reg        <= ptr_next;
            cmp_valid_reg  <= cmp_valid_next;
            served_cnt_reg <= served_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_ptr_reg   <= cmp_ptr_next;
        target_reg    <= target_next;
        found_reg     <= found_next;
        pos_reg       <= pos_next;
        out_pos_reg   <= out_pos_next;
        out_found_reg <= out_found_next;
    end

    assign result_valid   = out_valid_reg;
    assign print_position = out_pos_reg;
    assign found          = out_found_reg;

endmodule

// ===== src/prp_level_track.sv =====
// Per-level waiting-job counters and the highest-waiting-level encoder.
// Depends on prp_pkg.
module prp_level_track
    import prp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  lvl_ctrl_t        ctrl,
    output logic [LVL_W-1:0] top_level
);

    logic [CNT_W-1:0] hist_reg  [NUM_LVLS];
    logic [CNT_W-1:0] hist_next [NUM_LVLS];

    always_comb
    begin
        for (int lv = 0; lv < NUM_LVLS; lv++)
        begin
            hist_next[lv] = hist_reg[lv];
            if (ctrl.clr)
            begin
                hist_next[lv] = '0;
            end
            else if (ctrl.inc && (ctrl.inc_lvl == LVL_W'(lv)))
            begin
                hist_next[lv] = hist_reg[lv] + CNT_W'(1);
            end
            else if (ctrl.dec && (ctrl.dec_lvl == LVL_W'(lv)))
            begin
                hist_next[lv] = hist_reg[lv] - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int lv = 0; lv < NUM_LVLS; lv++)
            begin
                hist_reg[lv] <= '0;
            end
        end
        else
        begin
            for (int lv = 0; lv < NUM_LVLS; lv++)
            begin
                hist_reg[lv] <= hist_next[lv];
            end
        end
    end

    // level 0 is the floor: reported when nothing above it waits
    always_comb
    begin
        top_level = '0;
        for (int lv = 1; lv < NUM_LVLS; lv++)
        begin
            if (hist_reg[lv] != '0)
            begin
                top_level = LVL_W'(lv);
            end
        end
    end

endmodule
